FILE: design/trilinear_harmonic_interp_top_assert.svh
// assertion macros for the trilinear harmonic interpolator
// used by the divider and the top level, no other dependencies
`ifndef TRILINEAR_HARMONIC_INTERP_TOP_ASSERT_SVH
`define TRILINEAR_HARMONIC_INTERP_TOP_ASSERT_SVH

// same-cycle implication
`define THI_ASSERT_IMPL(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("thi assertion failed");

// next-cycle implication
`define THI_ASSERT_NEXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("thi assertion failed");

`endif

FILE: design/thi_pkg.sv
// shared constants and types for the trilinear harmonic interpolator
// no dependencies
`default_nettype none
package thi_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF   = 16;
  localparam int unsigned NUM_CORNERS     = 8;
  // restoring division steps per pipeline register
  localparam int unsigned DIV_STEPS       = 4;

  typedef struct packed {
    logic harm;   // all corners share a sign
    logic neg;    // all corners negative
    logic zero;   // harmonic sum is zero
  } thi_flags_t;

endpackage
`default_nettype wire

FILE: design/thi_div.sv
// pipelined restoring divider of the constant 2^(NW-1) by LANES divisors
// carries a sideband word alongside; depends on thi_pkg and the assert header
`default_nettype none
`include "trilinear_harmonic_interp_top_assert.svh"
module thi_div #(
  parameter int unsigned DW    = 32,
  parameter int unsigned NW    = 47,
  parameter int unsigned LANES = 8,
  parameter int unsigned SPS   = thi_pkg::DIV_STEPS,
  parameter int unsigned SW    = 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [LANES-1:0][DW-1:0]      divisor,
  input  logic [SW-1:0]                 side_in,
  output logic                          out_valid,
  output logic [LANES-1:0][NW-1:0]      quot,
  output logic [SW-1:0]                 side_out
);
  import thi_pkg::*;

  localparam int unsigned STAGES = (NW + SPS - 1) / SPS;

  logic                     vld [STAGES];
  logic [LANES-1:0][DW-1:0] dv  [STAGES];
  logic [LANES-1:0][DW-1:0] rm  [STAGES];
  logic [LANES-1:0][NW-1:0] qt  [STAGES];
  logic [SW-1:0]            sd  [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic                     vin;
    logic [LANES-1:0][DW-1:0] din, rin;
    logic [LANES-1:0][NW-1:0] qin;
    logic [SW-1:0]            sin;
    logic [LANES-1:0][DW-1:0] rm_next;
    logic [LANES-1:0][NW-1:0] qt_next;

    if (s == 0) begin : g_first
      assign vin = in_valid;
      assign din = divisor;
      assign rin = '0;
      assign qin = '0;
      assign sin = side_in;
    end else begin : g_rest
      assign vin = vld[s-1];
      assign din = dv[s-1];
      assign rin = rm[s-1];
      assign qin = qt[s-1];
      assign sin = sd[s-1];
    end

    always_comb begin
      logic [DW:0] t;
      rm_next = rin;
      qt_next = qin;
      t = '0;
      for (int l = 0; l < LANES; l++) begin
        for (int j = 0; j < SPS; j++) begin
          if (s * SPS + j < NW) begin
            // only the top numerator bit is set
            t = {rm_next[l], (s * SPS + j == 0) ? 1'b1 : 1'b0};
            if (t >= {1'b0, din[l]}) begin
              t = t - {1'b0, din[l]};
              qt_next[l] = {qt_next[l][NW-2:0], 1'b1};
            end else begin
              qt_next[l] = {qt_next[l][NW-2:0], 1'b0};
            end
            rm_next[l] = t[DW-1:0];
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= vin;
      end
      if (en) begin
        dv[s] <= din;
        rm[s] <= rm_next;
        qt[s] <= qt_next;
        sd[s] <= sin;
      end
    end
  end

  assign out_valid = vld[STAGES-1];
  assign quot      = qt[STAGES-1];
  assign side_out  = sd[STAGES-1];

  `THI_ASSERT_NEXT(a_div_hold, clk, rst, !en, $stable(out_valid))

endmodule
`default_nettype wire

FILE: design/thi_blend.sv
// three-stage blend along x, y and z, shared by the arithmetic and harmonic modes
// depends on thi_pkg
`default_nettype none
module thi_blend #(
  parameter int unsigned VW = thi_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned FB = thi_pkg::FRAC_BITS_DEF,
  parameter int unsigned NW = 3 * thi_pkg::FRAC_BITS_DEF - 1,
  parameter int unsigned OW = ((NW > VW) ? NW : VW) + 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  thi_pkg::thi_flags_t      in_flags,
  input  logic [7:0][VW-1:0]       corners,
  input  logic [7:0][NW-1:0]       recips,
  input  logic [FB:0]              fx,
  input  logic [FB:0]              fy,
  input  logic [FB:0]              fz,
  output logic                     out_valid,
  output thi_pkg::thi_flags_t      out_flags,
  output logic signed [OW-1:0]     result
);
  import thi_pkg::*;

  localparam int unsigned PW = OW + FB + 3;
  localparam logic signed [FB+1:0] ONE_F = signed'((FB + 2)'(1) << FB);

  // floor((a*(1-f) + b*f) / 2^FB), equal to a + floor((b-a)*f / 2^FB)
  function automatic logic signed [OW-1:0] lerp(input logic signed [OW-1:0] a,
                                                input logic signed [OW-1:0] b,
                                                input logic [FB:0] f);
    logic signed [FB+1:0] fs;
    logic signed [FB+1:0] gs;
    logic signed [PW-1:0] p;
    fs = signed'({1'b0, f});
    gs = ONE_F - fs;
    p = PW'(a) * PW'(gs) + PW'(b) * PW'(fs);
    return p[FB +: OW];
  endfunction

  logic signed [OW-1:0] op [NUM_CORNERS];

  always_comb begin
    for (int i = 0; i < NUM_CORNERS; i++) begin
      op[i] = in_flags.harm ? signed'(OW'(recips[i])) : OW'(signed'(corners[i]));
    end
  end

  // stage x
  logic                 vx;
  thi_flags_t           flx;
  logic [FB:0]          fyx, fzx;
  logic signed [OW-1:0] bx [4];
  // stage y
  logic                 vy;
  thi_flags_t           fly;
  logic [FB:0]          fzy;
  logic signed [OW-1:0] by [2];
  // stage z
  logic                 vz;
  thi_flags_t           flz;
  logic signed [OW-1:0] bz;

  always_ff @(posedge clk) begin
    if (rst) begin
      vx <= 1'b0;
      vy <= 1'b0;
      vz <= 1'b0;
    end else if (en) begin
      vx <= in_valid;
      vy <= vx;
      vz <= vy;
    end
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        bx[k] <= lerp(op[2*k], op[2*k+1], fx);
      end
      flx   <= in_flags;
      fyx   <= fy;
      fzx   <= fz;
      by[0] <= lerp(bx[0], bx[1], fyx);
      by[1] <= lerp(bx[2], bx[3], fyx);
      fly   <= flx;
      fzy   <= fzx;
      bz    <= lerp(by[0], by[1], fzy);
      flz   <= fly;
    end
  end

  assign out_valid = vz;
  assign out_flags = flz;
  assign result    = bz;

endmodule
`default_nettype wire

FILE: design/trilinear_harmonic_interp_top.sv
// throughput: one request per cycle unless the output stalls; set by the two
// pipelined reciprocal dividers (four restoring steps per register) and the
// three blend multiplier stages
// a stalled output freezes the whole pipeline
// reset clears only the valid bits, payload registers are not reset
`default_nettype none
`include "trilinear_harmonic_interp_top_assert.svh"
module trilinear_harmonic_interp_top #(
  parameter int unsigned VALUE_WIDTH = thi_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = thi_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [VALUE_WIDTH-1:0] corner_000,
  input  logic signed [VALUE_WIDTH-1:0] corner_100,
  input  logic signed [VALUE_WIDTH-1:0] corner_010,
  input  logic signed [VALUE_WIDTH-1:0] corner_110,
  input  logic signed [VALUE_WIDTH-1:0] corner_001,
  input  logic signed [VALUE_WIDTH-1:0] corner_101,
  input  logic signed [VALUE_WIDTH-1:0] corner_011,
  input  logic signed [VALUE_WIDTH-1:0] corner_111,
  input  logic [FRAC_BITS:0]            frac_x,
  input  logic [FRAC_BITS:0]            frac_y,
  input  logic [FRAC_BITS:0]            frac_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [VALUE_WIDTH-1:0] interp_value,
  output logic                          used_harmonic,
  output logic                          zero_sum_error
);
  import thi_pkg::*;

  localparam int unsigned VW  = VALUE_WIDTH;
  localparam int unsigned FB  = FRAC_BITS;
  localparam int unsigned NW  = 3 * FB - 1;
  localparam int unsigned OW  = ((NW > VW) ? NW : VW) + 1;
  localparam int unsigned MW  = OW;
  localparam int unsigned FLW = $bits(thi_flags_t);
  localparam int unsigned SW1 = NUM_CORNERS * VW + 3 * (FB + 1) + FLW;
  localparam int unsigned SW2 = FLW + VW;
  localparam logic [FB:0]    ONE_F = (FB + 1)'(1) << FB;
  localparam logic [MW-1:0]  CAP   = MW'(1) << (VW - 1);
  localparam logic [MW-1:0]  MAXP  = CAP - MW'(1);

  logic en;
  assign in_stall = out_valid & out_stall;
  assign en       = ~in_stall;

  // front end: sign check, magnitudes, offset clamp
  logic [7:0][VW-1:0] cin;
  logic [7:0]         signs;
  logic [7:0][VW-1:0] mag;
  thi_flags_t         fl_in;

  always_comb begin
    cin = {corner_111, corner_011, corner_101, corner_001,
           corner_110, corner_010, corner_100, corner_000};
    for (int i = 0; i < NUM_CORNERS; i++) begin
      signs[i] = cin[i][VW-1];
      mag[i]   = cin[i][VW-1] ? (~cin[i] + VW'(1)) : cin[i];
    end
    fl_in.harm = (signs == '0) || (signs == '1);
    fl_in.neg  = &signs;
    fl_in.zero = 1'b0;
  end

  logic               v0;
  logic [7:0][VW-1:0] c0, m0;
  logic [FB:0]        fx0, fy0, fz0;
  thi_flags_t         fl0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
    if (en) begin
      c0  <= cin;
      m0  <= mag;
      fx0 <= (frac_x > ONE_F) ? ONE_F : frac_x;
      fy0 <= (frac_y > ONE_F) ? ONE_F : frac_y;
      fz0 <= (frac_z > ONE_F) ? ONE_F : frac_z;
      fl0 <= fl_in;
    end
  end

  // corner reciprocals; a zero magnitude yields all ones, the saturated value
  logic               v1;
  logic [7:0][NW-1:0] r1;
  logic [SW1-1:0]     s1;

  thi_div #(
    .DW(VW), .NW(NW), .LANES(NUM_CORNERS), .SPS(DIV_STEPS), .SW(SW1)
  ) u_recip (
    .clk(clk), .rst(rst), .en(en), .in_valid(v0),
    .divisor(m0),
    .side_in({c0, fx0, fy0, fz0, fl0}),
    .out_valid(v1), .quot(r1), .side_out(s1)
  );

  logic               v2;
  thi_flags_t         fl2;
  logic signed [OW-1:0] res2;

  thi_blend #(.VW(VW), .FB(FB), .NW(NW), .OW(OW)) u_blend (
    .clk(clk), .rst(rst), .en(en), .in_valid(v1),
    .in_flags(s1[FLW-1:0]),
    .corners(s1[SW1-1 -: NUM_CORNERS*VW]),
    .recips(r1),
    .fx(s1[FLW + 3*(FB+1) - 1 -: FB+1]),
    .fy(s1[FLW + 2*(FB+1) - 1 -: FB+1]),
    .fz(s1[FLW + (FB+1) - 1 -: FB+1]),
    .out_valid(v2), .out_flags(fl2), .result(res2)
  );

  // final reciprocal of the blended harmonic sum
  thi_flags_t    fl2z;
  logic [NW-1:0] h2;

  always_comb begin
    h2        = res2[NW-1:0];
    fl2z      = fl2;
    fl2z.zero = fl2.harm && (h2 == '0);
  end

  logic             v3;
  logic [NW-1:0]    q3;
  logic [SW2-1:0]   s3;

  thi_div #(
    .DW(NW), .NW(NW), .LANES(1), .SPS(DIV_STEPS), .SW(SW2)
  ) u_final (
    .clk(clk), .rst(rst), .en(en), .in_valid(v2),
    .divisor(h2),
    .side_in({fl2z, res2[VW-1:0]}),
    .out_valid(v3), .quot(q3), .side_out(s3)
  );

  thi_flags_t    fl3;
  logic [VW-1:0] arith3;
  logic [MW-1:0] qx;
  logic [MW-1:0] qcap;
  logic [VW-1:0] value_next;

  always_comb begin
    fl3    = s3[SW2-1 -: FLW];
    arith3 = s3[VW-1:0];
    qx     = MW'(q3);
    qcap   = (qx > CAP) ? CAP : qx;
    priority if (!fl3.harm) begin
      value_next = arith3;
    end else if (fl3.zero) begin
      value_next = '0;
    end else if (fl3.neg) begin
      value_next = VW'(~qcap + MW'(1));
    end else begin
      value_next = (qx > MAXP) ? VW'(MAXP) : VW'(qx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v3;
    end
    if (en) begin
      interp_value   <= signed'(value_next);
      used_harmonic  <= fl3.harm;
      zero_sum_error <= fl3.zero;
    end
  end

  `THI_ASSERT_IMPL(a_err_harm, clk, rst, out_valid && zero_sum_error, used_harmonic)
  `THI_ASSERT_IMPL(a_err_zero, clk, rst, out_valid && zero_sum_error, interp_value == '0)
  `THI_ASSERT_IMPL(a_neg_sign, clk, rst, v3 && fl3.harm && fl3.neg && !fl3.zero && (qx != '0), value_next[VW-1])

endmodule
`default_nettype wire
